// ===== src/lrb_pkg.sv =====
`default_nettype none

package lrb_pkg;

  // Channel width; the all-ones value stands for 1.0
  localparam int CHANNEL_BITS   = 16;
  localparam int PROD_BITS      = 2 * CHANNEL_BITS;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [CHANNEL_BITS-1:0]   chan_t;
  typedef logic [PROD_BITS-1:0]      prod_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  localparam chan_t FULL = '1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OPACITY  = CFG_INDEX_BITS'(0),
    REG_USE_MASK = CFG_INDEX_BITS'(1)
  } cfg_reg_t;

  // Pixel data carried alongside the ratio divider
  typedef struct packed {
    chan_t [2:0] base;
    chan_t [2:0] layer;
    chan_t       alpha;
    logic        eor;
  } lrb_side_t;

  // Truncating divide by FULL, exact for any product of two channel values
  function automatic chan_t div_full(prod_t x);
    logic [PROD_BITS:0] sum;
    sum = {1'b0, x}
        + {{(CHANNEL_BITS + 1){1'b0}}, x[PROD_BITS-1:CHANNEL_BITS]}
        + (PROD_BITS + 1)'(1);
    return sum[PROD_BITS-1:CHANNEL_BITS];
  endfunction

endpackage

`default_nettype wire

// ===== src/lrb_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, quotient saturated
// to FULL when it would not fit in a channel.
module lrb_div import lrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  prod_t     num,
  input  chan_t     den,
  input  lrb_side_t side_in,
  output logic      out_valid,
  output chan_t     quo,
  output lrb_side_t side_out
);

  logic      v   [0:CHANNEL_BITS];
  prod_t     n   [0:CHANNEL_BITS];
  chan_t     d   [0:CHANNEL_BITS];
  chan_t     rem [0:CHANNEL_BITS];
  chan_t     q   [0:CHANNEL_BITS];
  logic      sat [0:CHANNEL_BITS];
  lrb_side_t sd  [0:CHANNEL_BITS];

  // Load: the high half starts the remainder; flag overflow of the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      n[0]   <= num;
      d[0]   <= den;
      rem[0] <= num[PROD_BITS-1:CHANNEL_BITS];
      sat[0] <= (num[PROD_BITS-1:CHANNEL_BITS] >= den);
      q[0]   <= '0;
      sd[0]  <= side_in;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= CHANNEL_BITS; k++) begin : g_step
    logic [CHANNEL_BITS:0] shifted;
    logic [CHANNEL_BITS:0] trial;
    logic                  ge;

    always_comb begin
      shifted = {rem[k-1], n[k-1][CHANNEL_BITS-k]};
      trial   = shifted - {1'b0, d[k-1]};
      ge      = (shifted >= {1'b0, d[k-1]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        n[k]   <= n[k-1];
        d[k]   <= d[k-1];
        rem[k] <= ge ? trial[CHANNEL_BITS-1:0] : shifted[CHANNEL_BITS-1:0];
        q[k]   <= {q[k-1][CHANNEL_BITS-2:0], ge};
        sat[k] <= sat[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign out_valid = v[CHANNEL_BITS];
  assign quo       = sat[CHANNEL_BITS] ? FULL : q[CHANNEL_BITS];
  assign side_out  = sd[CHANNEL_BITS];

endmodule

`default_nettype wire

// ===== src/layer_replace_blend.sv =====
`default_nettype none

// Replace-mode layer compositing, one pixel per transfer, no state between
// pixels. Each pixel gets weight = opacity (times mask when use_mask is set),
// new alpha = base alpha moved toward layer alpha by the weight, and each
// colour moved from base toward layer by min(1.0, weight*layer_alpha/alpha);
// a zero new alpha passes the base colours. All values are unsigned 0.16
// fractions and every step truncates. The block is a fixed pipeline that
// takes a pixel every clock while the output is not stalled, its depth set
// mostly by the one-bit-per-stage ratio divider. A stall on the output
// freezes the whole pipeline and is passed back as in_stall.
// Configuration writes are always ready and should be made while no pixel
// is in flight.
module layer_replace_blend import lrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  // Pixel input
  input  logic       in_valid,
  output logic       in_stall,
  input  chan_t      base_red,
  input  chan_t      base_green,
  input  chan_t      base_blue,
  input  chan_t      base_alpha,
  input  chan_t      layer_red,
  input  chan_t      layer_green,
  input  chan_t      layer_blue,
  input  chan_t      layer_alpha,
  input  chan_t      mask_value,
  input  logic       end_of_run,
  // Pixel output
  output logic       out_valid,
  input  logic       out_stall,
  output chan_t      out_red,
  output chan_t      out_green,
  output chan_t      out_blue,
  output chan_t      out_alpha,
  output logic       run_done
);

  typedef struct packed {
    chan_t [2:0] base;
    chan_t [2:0] layer;
    chan_t       base_a;
    chan_t       layer_a;
    logic        eor;
  } px_t;

  chan_t opacity;
  logic  use_mask;
  logic  en;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity  <= FULL;
      use_mask <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OPACITY) begin
        opacity <= CHANNEL_BITS'(cfg_data);
      end else if (cfg_index == REG_USE_MASK) begin
        use_mask <= cfg_data[0];
      end
    end
  end

  // Freeze everything while the output transfer is held off
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: capture pixel, opacity times mask
  logic  s1_v;
  px_t   s1_px;
  prod_t s1_wprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_px.base    <= {base_blue, base_green, base_red};
      s1_px.layer   <= {layer_blue, layer_green, layer_red};
      s1_px.base_a  <= base_alpha;
      s1_px.layer_a <= layer_alpha;
      s1_px.eor     <= end_of_run;
      s1_wprod      <= prod_t'(opacity) * prod_t'(mask_value);
    end
  end

  // Stage 2: weight, alpha difference and direction
  logic  s2_v;
  px_t   s2_px;
  chan_t s2_w;
  chan_t s2_adiff;
  logic  s2_aup;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_px    <= s1_px;
      s2_w     <= use_mask ? div_full(s1_wprod) : opacity;
      s2_aup   <= (s1_px.layer_a > s1_px.base_a);
      s2_adiff <= (s1_px.layer_a > s1_px.base_a) ? s1_px.layer_a - s1_px.base_a
                                                  : s1_px.base_a - s1_px.layer_a;
    end
  end

  // Stage 3: alpha step product and ratio numerator
  logic  s3_v;
  px_t   s3_px;
  prod_t s3_astep;
  prod_t s3_nprod;
  logic  s3_aup;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_px    <= s2_px;
      s3_aup   <= s2_aup;
      s3_astep <= prod_t'(s2_adiff) * prod_t'(s2_w);
      s3_nprod <= prod_t'(s2_w) * prod_t'(s2_px.layer_a);
    end
  end

  // Stage 4: new alpha
  logic  s4_v;
  px_t   s4_px;
  chan_t s4_alpha;
  prod_t s4_nprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
    if (en) begin
      s4_px    <= s3_px;
      s4_nprod <= s3_nprod;
      s4_alpha <= s3_aup ? s3_px.base_a + div_full(s3_astep)
                         : s3_px.base_a - div_full(s3_astep);
    end
  end

  // Ratio = min(FULL, weight*layer_alpha / alpha)
  lrb_side_t div_side_in;
  lrb_side_t d_side;
  logic      d_v;
  chan_t     d_ratio;

  always_comb begin
    div_side_in.base  = s4_px.base;
    div_side_in.layer = s4_px.layer;
    div_side_in.alpha = s4_alpha;
    div_side_in.eor   = s4_px.eor;
  end

  lrb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_v),
    .num       (s4_nprod),
    .den       (s4_alpha),
    .side_in   (div_side_in),
    .out_valid (d_v),
    .quo       (d_ratio),
    .side_out  (d_side)
  );

  // Stage 5: colour step products
  logic            s5_v;
  lrb_side_t       s5_side;
  prod_t     [2:0] s5_cprod;
  logic      [2:0] s5_up;
  logic            s5_zero;
  prod_t     [2:0] cprod_next;
  logic      [2:0] up_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      up_next[c]    = (d_side.layer[c] > d_side.base[c]);
      cprod_next[c] = prod_t'(up_next[c] ? d_side.layer[c] - d_side.base[c]
                                         : d_side.base[c] - d_side.layer[c])
                    * prod_t'(d_ratio);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= d_v;
    end
    if (en) begin
      s5_side  <= d_side;
      s5_cprod <= cprod_next;
      s5_up    <= up_next;
      s5_zero  <= (d_side.alpha == '0);
    end
  end

  // Stage 6: output register
  chan_t [2:0] colour_next;
  chan_t [2:0] colour;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s5_zero) begin
        colour_next[c] = s5_side.base[c];
      end else if (s5_up[c]) begin
        colour_next[c] = s5_side.base[c] + div_full(s5_cprod[c]);
      end else begin
        colour_next[c] = s5_side.base[c] - div_full(s5_cprod[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s5_v;
    end
    if (en) begin
      colour    <= colour_next;
      out_alpha <= s5_side.alpha;
      run_done  <= s5_side.eor;
    end
  end

  assign out_red   = colour[0];
  assign out_green = colour[1];
  assign out_blue  = colour[2];

  // New alpha stays between base and layer alpha
  a_alpha_bounded: assert property (@(posedge clk) disable iff (rst)
    s4_v |-> ((s4_px.base_a <= s4_alpha && s4_alpha <= s4_px.layer_a) ||
              (s4_px.layer_a <= s4_alpha && s4_alpha <= s4_px.base_a)))
    else $error("new alpha outside base/layer range");

  // Weight never exceeds opacity
  a_weight_bounded: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (s2_w <= opacity))
    else $error("weight exceeds opacity");

  // A held output freezes the inner stages
  a_hold_inner: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ($stable(s4_v) && $stable(s4_alpha) && $stable(s5_v)))
    else $error("pipeline advanced during stall");

endmodule

`default_nettype wire
